/* rtl/core/slru_pkg.sv */
`timescale 1ns / 1ps
package slru_pkg;

  localparam int KEY_BITS    = 16;
  localparam int SIZE_BITS   = 24;
  localparam int BUDGET_BITS = 24;
  localparam int ENTRIES_DEF = 16;
  localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 24'd65536;

  typedef enum logic [1:0] {
    KIND_EVICT  = 2'd0,
    KIND_HIT    = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  item_key;
    logic [SIZE_BITS-1:0] item_size;
  } in_t;

  typedef struct packed {
    kind_t                kind;
    logic [KEY_BITS-1:0]  key;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] used_after;
    logic                 last;
  } out_t;

  // one cached entry as held in a cell
  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  key;
    logic [SIZE_BITS-1:0] size;
  } ent_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic move_hit;  // move-to-front of the hit entry
    logic push;      // insert at the front, everything shifts back
    logic evict;     // this cell holds the LRU entry being dropped
  } cell_ctrl_t;

endpackage

/* rtl/core/slru_cell.sv */
`timescale 1ns / 1ps
module slru_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slru_pkg::cell_ctrl_t          ctrl,
  input  logic [slru_pkg::KEY_BITS-1:0] look_key,
  input  slru_pkg::ent_t                prev_ent,
  input  logic                          hit_below_in,
  input  slru_pkg::ent_t                sel_in,
  output slru_pkg::ent_t                ent,
  output logic                          hit_below_out,
  output slru_pkg::ent_t                sel_out
);
  import slru_pkg::*;

  ent_t ent_r, ent_nxt;
  logic match;
  logic shift;

  // lookup compare and chains toward the front
  assign match         = ent_r.valid && (ent_r.key == look_key);
  assign hit_below_out = match | hit_below_in;
  assign sel_out       = sel_in | (match ? ent_r : '0);
  assign shift         = ctrl.push | (ctrl.move_hit & hit_below_out);

  always_comb begin
    ent_nxt = ent_r;
    if (shift) begin
      ent_nxt = prev_ent;
    end else if (ctrl.evict) begin
      ent_nxt.valid = 1'b0;
    end
  end

  // valid cleared at reset, payload untouched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.key  <= ent_nxt.key;
    ent_r.size <= ent_nxt.size;
  end

  assign ent = ent_r;

endmodule

/* rtl/core/size_budget_lru_cache.sv */
`timescale 1ns / 1ps
// Size-budgeted LRU cache.
// Input: a request beat (item_key, item_size) is taken when start is high
// and busy is low. Results come out on out_data, each marked by out_valid
// for exactly one cycle; the receiver cannot stall, so every strobed beat
// is final. The last result of a request has last set.
// Config: cfg_data (memory budget) written when cfg_valid and cfg_ready;
// cfg_ready is always high, write only while busy is low.
// Entries live in a row of cells ordered by recency, cell 0 most recent.
// Sequence: a hit or reject gives its one result, decided in the lookup state,
// and the block then returns to idle. A miss goes from lookup to the fill
// state, which gives one result per evicted entry and then one insert
// result, evictions bounded by ENTRIES.
// The sequencer handles one request at a time; the eviction loop sets the
// miss latency.
// Reset: all entries invalid, use zero, budget 65536. No clearing pass.
module size_budget_lru_cache #(
  parameter int ENTRIES = slru_pkg::ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  slru_pkg::in_t                    in_data,
  output logic                             out_valid,
  output slru_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slru_pkg::BUDGET_BITS-1:0] cfg_data
);
  import slru_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int FW = ((SIZE_BITS > BUDGET_BITS) ? SIZE_BITS : BUDGET_BITS) + 1;

  state_t state_r, state_nxt;
  in_t    req_r;
  logic [BUDGET_BITS-1:0] budget_r;
  logic [SIZE_BITS-1:0]   used_r, used_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_r, out_nxt;

  cell_ctrl_t ctrl [ENTRIES];
  ent_t       ents [ENTRIES];
  ent_t       prev [ENTRIES];
  logic       hb   [ENTRIES+1];
  ent_t       sel  [ENTRIES+1];
  ent_t       head;

  logic [IW-1:0] lru_idx;
  ent_t          lru_ent;
  logic          hit;
  logic          too_big;
  logic          need_evict;
  logic          do_hit, do_push, do_evict;
  logic [FW-1:0] fit_sum;

  // cell row
  assign hb[ENTRIES]  = 1'b0;
  assign sel[ENTRIES] = '0;
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign prev[g] = head;
      end else begin : g_body
        assign prev[g] = ents[g-1];
      end
      assign ctrl[g].move_hit = do_hit;
      assign ctrl[g].push     = do_push;
      assign ctrl[g].evict    = do_evict && (lru_idx == IW'(g));
      slru_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl[g]),
        .look_key     (req_r.item_key),
        .prev_ent     (prev[g]),
        .hit_below_in (hb[g+1]),
        .sel_in       (sel[g+1]),
        .ent          (ents[g]),
        .hit_below_out(hb[g]),
        .sel_out      (sel[g])
      );
    end
  endgenerate

  assign hit     = hb[0];
  assign lru_idx = IW'(cnt_r - CW'(1));
  assign lru_ent = ents[lru_idx];
  assign too_big = FW'(req_r.item_size) > FW'(budget_r);
  assign fit_sum = FW'(used_r) + FW'(req_r.item_size);
  assign need_evict = ((fit_sum > FW'(budget_r)) || (cnt_r >= CW'(ENTRIES)))
                      && (cnt_r != '0);

  // front data: hit entry on move, new item on insert
  always_comb begin
    head = sel[0];
    if (!hit) begin
      head.valid = 1'b1;
      head.key   = req_r.item_key;
      head.size  = req_r.item_size;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_LOOK;
      ST_LOOK: begin
        if (hit || too_big) state_nxt = ST_IDLE;
        else                state_nxt = ST_FILL;
      end
      ST_FILL: if (!need_evict) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    do_hit        = 1'b0;
    do_push       = 1'b0;
    do_evict      = 1'b0;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: ;
      ST_LOOK: begin
        if (hit) begin
          do_hit        = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = '{KIND_HIT, req_r.item_key, sel[0].size, used_r, 1'b1};
        end else if (too_big) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{KIND_REJECT, req_r.item_key, req_r.item_size, used_r, 1'b1};
        end
      end
      ST_FILL: begin
        out_valid_nxt = 1'b1;
        if (need_evict) begin
          do_evict = 1'b1;
          used_nxt = (used_r >= lru_ent.size) ? used_r - lru_ent.size : '0;
          cnt_nxt  = cnt_r - CW'(1);
          out_nxt  = '{KIND_EVICT, lru_ent.key, lru_ent.size, used_nxt, 1'b0};
        end else begin
          do_push  = 1'b1;
          used_nxt = used_r + req_r.item_size;
          cnt_nxt  = cnt_r + CW'(1);
          out_nxt  = '{KIND_INSERT, req_r.item_key, req_r.item_size, used_nxt, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cnt_r       <= '0;
      budget_r    <= BUDGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) budget_r <= cfg_data;
    end
    out_r <= out_nxt;
    if (state_r == ST_IDLE && start) req_r <= in_data;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy) else $error("final beat while busy");
  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_EVICT |-> !out_data.last)
    else $error("evict beat marked last");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES)) else $error("entry count overflow");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted request not worked");

endmodule

/* bench/tb_size_budget_lru_cache.sv */
`timescale 1ns / 1ps
module tb_size_budget_lru_cache;
  import slru_pkg::*;

  localparam int NSLOT = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [BUDGET_BITS-1:0] cfg_data = '0;

  size_budget_lru_cache dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the cache contents
  logic                 slot_valid [NSLOT];
  logic [KEY_BITS-1:0]  slot_key   [NSLOT];
  logic [SIZE_BITS-1:0] slot_size  [NSLOT];
  int unsigned          slot_rank  [NSLOT];
  int unsigned          slot_count;
  logic [SIZE_BITS-1:0] used_total;
  logic [BUDGET_BITS-1:0] budget_now;

  in_t  request_queue[$];
  out_t cache_results[$];
  int   errors = 0;
  int   cycles = 0;
  bit   no_idle = 1'b0;
  int   gap_left = 0;

  function automatic out_t mk(kind_t k, logic [KEY_BITS-1:0] key,
                              logic [SIZE_BITS-1:0] sz, logic lst);
    out_t r;
    r.kind = k;
    r.key = key;
    r.size = sz;
    r.used_after = used_total;
    r.last = lst;
    return r;
  endfunction

  function automatic logic needs_room(logic [SIZE_BITS-1:0] sz);
    logic [SIZE_BITS:0] tot;
    tot = {1'b0, used_total} + {1'b0, sz};
    return (tot > {1'b0, budget_now}) || (slot_count >= NSLOT);
  endfunction

  // expected results of one request, updating the shadow cache
  task automatic lru_cache_step(in_t req);
    int hit, lru, free_s;
    hit = -1;
    free_s = -1;
    for (int i = 0; i < NSLOT; i++)
      if (hit < 0 && slot_valid[i] && slot_key[i] == req.item_key) hit = i;
    if (hit >= 0) begin
      for (int i = 0; i < NSLOT; i++)
        if (slot_valid[i] && slot_rank[i] < slot_rank[hit]) slot_rank[i]++;
      slot_rank[hit] = 0;
      cache_results.push_back(mk(KIND_HIT, req.item_key, slot_size[hit], 1'b1));
      return;
    end
    if (req.item_size > budget_now) begin
      cache_results.push_back(mk(KIND_REJECT, req.item_key, req.item_size, 1'b1));
      return;
    end
    // evict from the LRU end until the item fits and a slot is free
    while (needs_room(req.item_size)) begin
      lru = -1;
      for (int i = 0; i < NSLOT; i++)
        if (slot_valid[i] && slot_count > 0 && slot_rank[i] == slot_count - 1) lru = i;
      if (lru < 0) break;
      slot_valid[lru] = 1'b0;
      used_total = (used_total >= slot_size[lru]) ? used_total - slot_size[lru] : '0;
      slot_count--;
      cache_results.push_back(mk(KIND_EVICT, slot_key[lru], slot_size[lru], 1'b0));
    end
    for (int i = 0; i < NSLOT; i++)
      if (free_s < 0 && !slot_valid[i]) free_s = i;
    if (free_s < 0) begin
      cache_results.push_back(mk(KIND_REJECT, req.item_key, req.item_size, 1'b1));
      return;
    end
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i]) slot_rank[i]++;
    slot_valid[free_s] = 1'b1;
    slot_key[free_s] = req.item_key;
    slot_size[free_s] = req.item_size;
    slot_rank[free_s] = 0;
    slot_count++;
    used_total = used_total + req.item_size;
    cache_results.push_back(mk(KIND_INSERT, req.item_key, req.item_size, 1'b1));
  endtask

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  // request driver: predicts on each accepted beat, then loads the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) lru_cache_step(in_data);
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (request_queue.size() > 0) begin
        in_data <= request_queue.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (cache_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = cache_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d actual %0d", want.kind, out_data.kind);
          errors++;
        end
        if (out_data.key !== want.key) begin
          $error("key: expected %h actual %h", want.key, out_data.key);
          errors++;
        end
        if (out_data.size !== want.size) begin
          $error("size: expected %h actual %h", want.size, out_data.size);
          errors++;
        end
        if (out_data.used_after !== want.used_after) begin
          $error("used_after: expected %h actual %h", want.used_after,
                 out_data.used_after);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b actual %b", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(logic [KEY_BITS-1:0] k, logic [SIZE_BITS-1:0] s);
    in_t r;
    r.item_key = k;
    r.item_size = s;
    request_queue.push_back(r);
  endtask

  task automatic write_budget(logic [BUDGET_BITS-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    budget_now = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (request_queue.size() > 0 || start || cache_results.size() > 0)
      @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic random_reqs(int n, int key_span, int size_top);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: push_req(KEY_BITS'($urandom_range(0, 65535)),
                    SIZE_BITS'($urandom_range(0, size_top)));
        1: push_req(KEY_BITS'($urandom_range(0, key_span)), SIZE_BITS'($urandom));
        2: push_req(KEY_BITS'($urandom_range(0, key_span)), '0);
        default: push_req(KEY_BITS'($urandom_range(0, key_span)),
                          SIZE_BITS'($urandom_range(0, size_top)));
      endcase
    end
  endtask

  initial begin
    logic [BUDGET_BITS-1:0] budgets [6];
    budgets = '{24'd65536, 24'd1000, 24'hFFFFFF, 24'd0, 24'd300, 24'd20000};
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 1'b0;
      slot_rank[i] = 0;
      slot_key[i] = '0;
      slot_size[i] = '0;
    end
    slot_count = 0;
    used_total = '0;
    budget_now = BUDGET_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, hit, reject, exact fit, full slots
    push_req(16'h0000, 24'd0);
    push_req(16'hFFFF, 24'd100);
    push_req(16'h0000, 24'd555);
    push_req(16'h1234, 24'hFFFFFF);
    push_req(16'h0001, 24'd65536);
    push_req(16'hFFFF, 24'd7);
    for (int i = 0; i < 17; i++) push_req(KEY_BITS'(32'h0100 + i), 24'd0);
    push_req(16'h0200, 24'd65000);
    drain();

    // random phases over several budgets
    for (int p = 0; p < 6; p++) begin
      write_budget(budgets[p]);
      no_idle = (p == 2);
      if (p == 2) begin
        // fill with large items, then the next phase lowers the budget below use
        random_reqs(40, 23, 32'h0FFFFF);
      end else begin
        random_reqs(52, 23, (budgets[p] == 0) ? 3 : int'(budgets[p] / 5));
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* size_budget_lru_cache.f */
rtl/core/slru_pkg.sv
rtl/core/slru_cell.sv
rtl/core/size_budget_lru_cache.sv
bench/tb_size_budget_lru_cache.sv
